[rtl/core/ntt_pm_pkg.sv]
// shared constants for the polynomial multiplier modulo 998244353
// no dependencies
package ntt_pm_pkg;
	localparam int COEFF_W = 30;
	localparam logic [COEFF_W-1:0] MODP = 30'd998244353;
	localparam int MAX_TERMS = 32;
	localparam int ADDR_W = $clog2(MAX_TERMS);
	localparam int LEN_W = ADDR_W + 1;
	localparam int PROD_W = 2 * COEFF_W;
	localparam int OUT_W = $clog2(2 * MAX_TERMS);
	// shared multiplier operand width and barrett residual width (below 3p)
	localparam int MUL_W = COEFF_W + 1;
	localparam int MULP_W = 2 * MUL_W;
	localparam int RED_W = COEFF_W + 2;
	localparam logic [MUL_W-1:0] BARRETT_MU = MUL_W'((64'd1 << PROD_W) / 64'(MODP));
endpackage

[rtl/core/ntt_polynomial_multiply.sv]
// polynomial multiplier modulo 998244353, depends on ntt_pm_pkg
// the first product word is computed after the final input word is taken, each further word
// after the previous one is taken; every word runs la terms through read, product, two barrett
// steps, fix-up and accumulate on one shared 31x31 multiplier
// throughput: one load word per cycle; input stalls until the last of la+lb-1 words is taken
// reset: asynchronous, clears lengths, phase and sequencer; stores need no clear
module ntt_polynomial_multiply (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [ntt_pm_pkg::COEFF_W-1:0] coeff,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ntt_pm_pkg::COEFF_W-1:0] product_coeff,
	output logic                        last_out
);
	import ntt_pm_pkg::*;

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_QM   = 3'd3;
	localparam logic [2:0] ST_PM   = 3'd4;
	localparam logic [2:0] ST_FIX  = 3'd5;
	localparam logic [2:0] ST_ACC  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam logic [RED_W-1:0] MODP_X1 = RED_W'(MODP);
	localparam logic [RED_W-1:0] MODP_X2 = RED_W'({MODP, 1'b0});

	logic [2:0]         state_q;
	logic               phase_q;
	logic [LEN_W-1:0]   la_q, lb_q;
	logic [OUT_W-1:0]   k_q;
	logic [ADDR_W-1:0]  i_q;
	logic [COEFF_W-1:0] mem_a [MAX_TERMS];
	logic [COEFF_W-1:0] mem_b [MAX_TERMS];
	logic [COEFF_W-1:0] a_rd_q, b_rd_q;
	logic               term_ok_q;
	logic [PROD_W-1:0]  prod_q;
	logic [MUL_W-1:0]   quot_q;
	logic [RED_W-1:0]   qp_q;
	logic [COEFF_W-1:0] res_q;
	logic [COEFF_W-1:0] acc_q;

	logic [COEFF_W-1:0] c_red;
	logic               in_acc, out_acc;
	logic [OUT_W-1:0]   need_m1;
	logic [OUT_W:0]     j_w;
	logic               j_ok;
	logic [MUL_W-1:0]   mul_x, mul_y;
	logic [MULP_W-1:0]  mul_p;
	logic [RED_W-1:0]   diff_w, sub1_w, sub2_w;
	logic [COEFF_W:0]   acc_sum, acc_red;

	// input reduction and handshake
	assign c_red = (coeff >= MODP) ? coeff - MODP : coeff;
	assign in_stall = (state_q != ST_LOAD);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_acc = out_valid && !out_stall;
	assign need_m1 = OUT_W'(la_q + lb_q - LEN_W'(2));
	assign product_coeff = acc_q;
	assign last_out = (k_q == need_m1);

	// second operand index for the current term
	assign j_w = {1'b0, k_q} - (OUT_W + 1)'(i_q);
	assign j_ok = !j_w[OUT_W] && (j_w < (OUT_W + 1)'(lb_q));

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_MUL: begin
				mul_x = {1'b0, a_rd_q};
				mul_y = {1'b0, b_rd_q};
			end
			ST_QM: begin
				mul_x = prod_q[PROD_W-1:COEFF_W-1];
				mul_y = BARRETT_MU;
			end
			ST_PM: begin
				mul_x = quot_q;
				mul_y = {1'b0, MODP};
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end
	assign mul_p = mul_x * mul_y;

	// barrett residual fix-up, residual below 3p
	assign diff_w = prod_q[RED_W-1:0] - qp_q;
	assign sub1_w = diff_w - MODP_X1;
	assign sub2_w = diff_w - MODP_X2;

	// modular accumulate
	assign acc_sum = {1'b0, acc_q} + {1'b0, res_q};
	assign acc_red = acc_sum - (COEFF_W + 1)'(MODP);

	// coefficient stores
	always_ff @(posedge clk) begin
		if (in_acc && func == phase_q) begin
			if (!phase_q && la_q < LEN_W'(MAX_TERMS))
				mem_a[la_q[ADDR_W-1:0]] <= c_red;
			if (phase_q && lb_q < LEN_W'(MAX_TERMS))
				mem_b[lb_q[ADDR_W-1:0]] <= c_red;
		end
		if (state_q == ST_RD) begin
			a_rd_q <= mem_a[i_q];
			b_rd_q <= mem_b[j_w[ADDR_W-1:0]];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD: term_ok_q <= j_ok;
			ST_MUL: prod_q <= term_ok_q ? mul_p[PROD_W-1:0] : '0;
			ST_QM: quot_q <= mul_p[MULP_W-1:MUL_W];
			ST_PM: qp_q <= mul_p[RED_W-1:0];
			ST_FIX: begin
				if (diff_w >= MODP_X2)
					res_q <= sub2_w[COEFF_W-1:0];
				else if (diff_w >= MODP_X1)
					res_q <= sub1_w[COEFF_W-1:0];
				else
					res_q <= diff_w[COEFF_W-1:0];
			end
			ST_ACC: acc_q <= acc_red[COEFF_W] ? acc_sum[COEFF_W-1:0] : acc_red[COEFF_W-1:0];
			ST_OUT: if (out_acc) acc_q <= '0;
			default: acc_q <= '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= 1'b0;
			la_q <= '0;
			lb_q <= '0;
			k_q <= '0;
			i_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc && func == phase_q) begin
						if (!phase_q) begin
							if (la_q < LEN_W'(MAX_TERMS)) la_q <= la_q + 1'b1;
							if (last) phase_q <= 1'b1;
						end else begin
							if (lb_q < LEN_W'(MAX_TERMS)) lb_q <= lb_q + 1'b1;
							if (last) begin
								state_q <= ST_RD;
								k_q <= '0;
								i_q <= '0;
							end
						end
					end
				end
				ST_RD: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_QM;
				ST_QM: state_q <= ST_PM;
				ST_PM: state_q <= ST_FIX;
				ST_FIX: state_q <= ST_ACC;
				ST_ACC: begin
					if (LEN_W'(i_q) == la_q - 1'b1) begin
						state_q <= ST_OUT;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						i_q <= '0;
						if (last_out) begin
							state_q <= ST_LOAD;
							phase_q <= 1'b0;
							la_q <= '0;
							lb_q <= '0;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// checks
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> acc_q < MODP) else $error("unreduced product word");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		la_q <= LEN_W'(MAX_TERMS) && lb_q <= LEN_W'(MAX_TERMS))
		else $error("length overflow");
	a_term_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> LEN_W'(i_q) < la_q) else $error("term index past length");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(product_coeff) && $stable(last_out))
		else $error("stalled product word changed");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_out |=> !in_stall && la_q == '0 && !phase_q)
		else $error("not idle after last word");
endmodule
